@@ sv/mnva_pkg.sv @@
`default_nettype none

package mnva_pkg;

    localparam int VOICE_COUNT_DEF = 4;

    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 32;
    localparam int NOTE_W  = 7;
    localparam int VOICE_W = 4;
    localparam int CHAN_W  = 5;
    localparam int EV_W    = 2;

    localparam logic [CHAN_W-1:0] CHAN_RESET = 5'd1;
    localparam logic [CHAN_W-1:0] CHAN_MIN   = 5'd1;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 5'd16;

    // status byte ranges
    localparam logic [BYTE_W-1:0] ST_SYSTEM_LO   = 8'hF0;
    localparam logic [BYTE_W-1:0] ST_REALTIME_LO = 8'hF8;
    localparam logic [BYTE_W-1:0] ST_CHANNEL_LO  = 8'h80;
    localparam logic [BYTE_W-1:0] ST_NOTE_HI     = 8'h9F;
    localparam logic [BYTE_W-1:0] ST_CC_LO       = 8'hB0;
    localparam logic [BYTE_W-1:0] ST_CC_HI       = 8'hBF;
    localparam logic [BYTE_W-1:0] ST_BEND_LO     = 8'hE0;
    localparam logic [BYTE_W-1:0] ST_BEND_HI     = 8'hEF;
    localparam logic [3:0]        ST_NOTE_OFF    = 4'h8;
    localparam logic [3:0]        ST_NOTE_ON     = 4'h9;

    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_START   = 2'd1;
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;

    // one voice as held in a ring cell
    typedef struct packed {
        logic [VOICE_W-1:0] idx;
        logic               gate;
        logic [NOTE_W-1:0]  note;
        logic [TIME_W-1:0]  stamp;
    } voice_t;

    // update broadcast to the cell whose index matches
    typedef struct packed {
        logic               en;
        logic [VOICE_W-1:0] idx;
        logic               gate;
        logic [NOTE_W-1:0]  note;
        logic [TIME_W-1:0]  stamp;
    } voice_wr_t;

    function automatic logic collects_two(input logic [BYTE_W-1:0] s);
        return (s >= ST_CHANNEL_LO && s <= ST_NOTE_HI) ||
               (s >= ST_CC_LO && s <= ST_CC_HI) ||
               (s >= ST_BEND_LO && s <= ST_BEND_HI);
    endfunction

endpackage

`default_nettype wire

@@ sv/midi_note_voice_allocator.sv @@
// MIDI voice allocator: one MIDI byte with its millisecond time is taken per word on the
// input channel and each byte gives exactly one result word (event, voice, note). Voices sit
// in a ring of VOICE_COUNT cells; a note-on or note-off on the selected channel rotates the
// ring once around to look for the held note, the next free voice and the oldest voice,
// then writes the update in the apply state and hands the result on. A byte is taken while the
// previous result still waits on the output register; the result stage then waits for it.
`default_nettype none

module midi_note_voice_allocator #(
    parameter int VOICE_COUNT = mnva_pkg::VOICE_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [mnva_pkg::CHAN_W-1:0]   cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mnva_pkg::BYTE_W-1:0]   midi_byte,
    input  wire logic [mnva_pkg::TIME_W-1:0]   time_ms,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mnva_pkg::EV_W-1:0]          event_res,
    output logic [mnva_pkg::VOICE_W-1:0]       voice,
    output logic [mnva_pkg::NOTE_W-1:0]        note
);

    localparam int VOICE_W = mnva_pkg::VOICE_W;
    localparam int NOTE_W  = mnva_pkg::NOTE_W;
    localparam int TIME_W  = mnva_pkg::TIME_W;
    localparam int BYTE_W  = mnva_pkg::BYTE_W;
    localparam int CHAN_W  = mnva_pkg::CHAN_W;
    localparam int EV_W    = mnva_pkg::EV_W;
    localparam int CNT_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(VOICE_COUNT - 1);
    localparam logic [VOICE_W-1:0] VOICE_LAST = VOICE_W'(VOICE_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [BYTE_W-1:0]  rs_reg, rs_next;
    logic               phase_reg, phase_next;
    logic [NOTE_W-1:0]  first_reg, first_next;
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic [VOICE_W-1:0] nv_reg, nv_next;

    logic               req_on_reg, req_on_next;
    logic [NOTE_W-1:0]  req_note_reg, req_note_next;
    logic [TIME_W-1:0]  req_time_reg, req_time_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               hit_found_reg, hit_found_next;
    logic [VOICE_W-1:0] hit_idx_reg, hit_idx_next;
    logic               free_found_reg, free_found_next;
    logic [VOICE_W-1:0] free_gap_reg, free_gap_next;
    logic [VOICE_W-1:0] free_idx_reg, free_idx_next;
    logic               old_found_reg, old_found_next;
    logic [TIME_W-1:0]  old_time_reg, old_time_next;
    logic [VOICE_W-1:0] old_idx_reg, old_idx_next;

    logic [EV_W-1:0]    res_event_reg, res_event_next;
    logic [VOICE_W-1:0] res_voice_reg, res_voice_next;
    logic [NOTE_W-1:0]  res_note_reg, res_note_next;

    logic               out_valid_reg, out_valid_next;
    logic [EV_W-1:0]    out_event_reg, out_event_next;
    logic [VOICE_W-1:0] out_voice_reg, out_voice_next;
    logic [NOTE_W-1:0]  out_note_reg, out_note_next;

    mnva_pkg::voice_t    ring [VOICE_COUNT];
    mnva_pkg::voice_t    tail;
    mnva_pkg::voice_wr_t wr;
    logic                shift_en;

    logic               chan_ok;
    logic [3:0]         chan_m1;
    logic               on_ch;
    logic               off_ch;
    logic [VOICE_W-1:0] rr_gap;
    logic [VOICE_W-1:0] target;

    // ring of voice cells, tail feeds head
    for (genvar gi = 0; gi < VOICE_COUNT; gi++)
    begin : g_cell
        localparam int UP = (gi == 0) ? VOICE_COUNT - 1 : gi - 1;
        mnva_cell #(
            .CELL_IDX (gi)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .up       (ring[UP]),
            .wr       (wr),
            .q        (ring[gi])
        );
    end

    assign tail     = ring[VOICE_COUNT-1];
    assign shift_en = (state_reg == S_SCAN);
    assign in_stall = (state_reg != S_IDLE);

    assign chan_ok = (chan_reg >= mnva_pkg::CHAN_MIN) && (chan_reg <= mnva_pkg::CHAN_MAX);
    assign chan_m1 = chan_reg[3:0] - 4'd1;
    assign on_ch   = chan_ok && (rs_reg == {mnva_pkg::ST_NOTE_ON, chan_m1});
    assign off_ch  = chan_ok && (rs_reg == {mnva_pkg::ST_NOTE_OFF, chan_m1});

    // round-robin distance of the tail voice from the round-robin pointer
    assign rr_gap = (tail.idx >= nv_reg)
                  ? (tail.idx - nv_reg)
                  : (tail.idx + VOICE_W'(VOICE_COUNT) - nv_reg);

    assign target = free_found_reg ? free_idx_reg : old_idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        rs_next         = rs_reg;
        phase_next      = phase_reg;
        first_next      = first_reg;
        chan_next       = cfg_we ? cfg_wdata : chan_reg;
        nv_next         = nv_reg;
        req_on_next     = req_on_reg;
        req_note_next   = req_note_reg;
        req_time_next   = req_time_reg;
        cnt_next        = cnt_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_gap_next   = free_gap_reg;
        free_idx_next   = free_idx_reg;
        old_found_next  = old_found_reg;
        old_time_next   = old_time_reg;
        old_idx_next    = old_idx_reg;
        res_event_next  = res_event_reg;
        res_voice_next  = res_voice_reg;
        res_note_next   = res_note_reg;
        out_valid_next  = out_valid_reg;
        out_event_next  = out_event_reg;
        out_voice_next  = out_voice_reg;
        out_note_next   = out_note_reg;
        wr              = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_event_next = mnva_pkg::EV_NONE;
                    res_voice_next = '0;
                    res_note_next  = '0;
                    state_next     = S_DONE;
                    if (midi_byte >= mnva_pkg::ST_REALTIME_LO)
                    begin
                        // realtime, no effect
                    end
                    else if (midi_byte >= mnva_pkg::ST_SYSTEM_LO)
                    begin
                        rs_next    = '0;
                        phase_next = 1'b0;
                    end
                    else if (midi_byte[BYTE_W-1])
                    begin
                        rs_next    = midi_byte;
                        phase_next = 1'b0;
                    end
                    else if (!mnva_pkg::collects_two(rs_reg))
                    begin
                        // stray data byte
                    end
                    else if (!phase_reg)
                    begin
                        first_next = midi_byte[NOTE_W-1:0];
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (on_ch || off_ch)
                        begin
                            req_on_next     = on_ch && (midi_byte[NOTE_W-1:0] != '0);
                            req_note_next   = first_reg;
                            req_time_next   = time_ms;
                            cnt_next        = '0;
                            hit_found_next  = 1'b0;
                            free_found_next = 1'b0;
                            old_found_next  = 1'b0;
                            state_next      = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // tail visits voices in falling index order, so later wins ties
                if (tail.gate && tail.note == req_note_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = tail.idx;
                end
                if (!tail.gate && (!free_found_reg || rr_gap < free_gap_reg))
                begin
                    free_found_next = 1'b1;
                    free_gap_next   = rr_gap;
                    free_idx_next   = tail.idx;
                end
                if (!old_found_reg || tail.stamp <= old_time_reg)
                begin
                    old_found_next = 1'b1;
                    old_time_next  = tail.stamp;
                    old_idx_next   = tail.idx;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_APPLY;
                end
            end

            S_APPLY:
            begin
                state_next = S_DONE;
                if (req_on_reg)
                begin
                    if (!hit_found_reg)
                    begin
                        wr.en          = 1'b1;
                        wr.idx         = target;
                        wr.gate        = 1'b1;
                        wr.note        = req_note_reg;
                        wr.stamp       = req_time_reg;
                        nv_next        = (target == VOICE_LAST) ? '0 : target + VOICE_W'(1);
                        res_event_next = mnva_pkg::EV_START;
                        res_voice_next = target;
                        res_note_next  = req_note_reg;
                    end
                end
                else if (hit_found_reg)
                begin
                    wr.en          = 1'b1;
                    wr.idx         = hit_idx_reg;
                    wr.gate        = 1'b0;
                    wr.note        = '0;
                    wr.stamp       = '0;
                    res_event_next = mnva_pkg::EV_RELEASE;
                    res_voice_next = hit_idx_reg;
                    res_note_next  = req_note_reg;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = res_event_reg;
                    out_voice_next = res_voice_reg;
                    out_note_next  = res_note_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rs_reg         <= '0;
            phase_reg      <= 1'b0;
            first_reg      <= '0;
            chan_reg       <= mnva_pkg::CHAN_RESET;
            nv_reg         <= '0;
            req_on_reg     <= 1'b0;
            req_note_reg   <= '0;
            req_time_reg   <= '0;
            cnt_reg        <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_gap_reg   <= '0;
            free_idx_reg   <= '0;
            old_found_reg  <= 1'b0;
            old_time_reg   <= '0;
            old_idx_reg    <= '0;
            res_event_reg  <= mnva_pkg::EV_NONE;
            res_voice_reg  <= '0;
            res_note_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_event_reg  <= mnva_pkg::EV_NONE;
            out_voice_reg  <= '0;
            out_note_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rs_reg         <= rs_next;
            phase_reg      <= phase_next;
            first_reg      <= first_next;
            chan_reg       <= chan_next;
            nv_reg         <= nv_next;
            req_on_reg     <= req_on_next;
            req_note_reg   <= req_note_next;
            req_time_reg   <= req_time_next;
            cnt_reg        <= cnt_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            free_found_reg <= free_found_next;
            free_gap_reg   <= free_gap_next;
            free_idx_reg   <= free_idx_next;
            old_found_reg  <= old_found_next;
            old_time_reg   <= old_time_next;
            old_idx_reg    <= old_idx_next;
            res_event_reg  <= res_event_next;
            res_voice_reg  <= res_voice_next;
            res_note_reg   <= res_note_next;
            out_valid_reg  <= out_valid_next;
            out_event_reg  <= out_event_next;
            out_voice_reg  <= out_voice_next;
            out_note_reg   <= out_note_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = out_event_reg;
    assign voice     = out_voice_reg;
    assign note      = out_note_reg;

    // ring is back in home position once a full rotation ends
    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> (ring[0].idx == '0 && tail.idx == VOICE_LAST))
        else $error("voice ring not realigned after scan");

    a_nv_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, nv_reg} < (VOICE_W+1)'(VOICE_COUNT))
        else $error("next voice out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted word not processed");

    a_wr_target: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_APPLY && {1'b0, wr.idx} < (VOICE_W+1)'(VOICE_COUNT)))
        else $error("voice update outside apply or to missing voice");

endmodule

`default_nettype wire

@@ sv/mnva_cell.sv @@
`default_nettype none

module mnva_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift_en,
    input  wire mnva_pkg::voice_t   up,
    input  wire mnva_pkg::voice_wr_t wr,
    output mnva_pkg::voice_t        q
);

    mnva_pkg::voice_t cell_reg;
    mnva_pkg::voice_t cell_next;

    always_comb
    begin
        cell_next = cell_reg;
        if (shift_en)
        begin
            cell_next = up;
        end
        else if (wr.en && wr.idx == cell_reg.idx)
        begin
            cell_next.gate  = wr.gate;
            cell_next.note  = wr.note;
            cell_next.stamp = wr.stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.idx   <= mnva_pkg::VOICE_W'(CELL_IDX);
            cell_reg.gate  <= 1'b0;
            cell_reg.note  <= '0;
            cell_reg.stamp <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;

endmodule

`default_nettype wire
